### hw/rtl/qdpr_pkg.sv
// Shared types and constants of the quantized dot product requantizer.
// No dependencies; every other file of the block but the checker imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qdpr_pkg;

  // accumulator width default, queue depth default
  localparam int ACC_WIDTH_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // fixed field widths
  localparam int PROD_W     = 18;
  localparam int BIAS_W     = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;
  localparam int SAT_W      = 40;

  // saturation masks on the 40-bit scaled value
  localparam logic [SAT_W-1:0] MASK_B7_38 = 40'h7F_FFFF_FF80;
  localparam logic [SAT_W-1:0] MASK_B8_39 = 40'hFF_FFFF_FF00;
  localparam logic [SAT_W-1:0] MASK_B39   = 40'h80_0000_0000;
  localparam logic [7:0]       SAT_POS_S  = 8'h7F;
  localparam logic [7:0]       SAT_NEG_S  = 8'h80;
  localparam logic [7:0]       SAT_POS_U  = 8'hFF;
  localparam logic [7:0]       SAT_NEG_U  = 8'h00;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACT_ZP      = 4'd0,
    CFG_WGT_ZP      = 4'd1,
    CFG_OUT_ZP      = 4'd2,
    CFG_SCALE_MULT  = 4'd3,
    CFG_SCALE_SHIFT = 4'd4,
    CFG_ROUND_MODE  = 4'd5,
    CFG_SIGNED_OUT  = 4'd6,
    CFG_RELU_EN     = 4'd7
  } cfg_idx_e;

  // rounding modes; the spare code truncates
  typedef enum logic [1:0] {
    RND_TRUNC     = 2'd0,
    RND_HALF_UP   = 2'd1,
    RND_HALF_EVEN = 2'd2
  } round_e;

  // configuration register set
  typedef struct packed {
    logic [7:0] act_zp;
    logic [7:0] wgt_zp;
    logic [8:0] out_zp;
    logic [7:0] scale_mult;
    logic [4:0] scale_shift;
    logic [1:0] round_mode;
    logic       signed_out;
    logic       relu_en;
  } cfg_t;

  // one classified word between front and back
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [BIAS_W-1:0] bias;
    logic              first;
    logic              last;
  } qitem_t;

endpackage

`default_nettype wire

### hw/rtl/quantized_dot_product_requantizer_core.sv
// Quantized dot product with requantization, top level.
// Throughput: one word per cycle; the back pipeline (accumulate, scale multiply,
// round, saturate) stalls as a whole while the output byte is not taken.
// Reset (rst_ni, async low) clears the accumulator and all valid flags and sets
// the registers to zero with half-up rounding.
`timescale 1ns / 1ps
`default_nettype none

module quantized_dot_product_requantizer_core #(
  parameter int ACC_WIDTH   = qdpr_pkg::ACC_WIDTH_DEF,
  parameter int QUEUE_DEPTH = qdpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qdpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [qdpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      act_elem_i,
  input  logic signed [7:0]               wgt_elem_i,
  input  logic signed [qdpr_pkg::BIAS_W-1:0] bias_value_i,
  input  logic                            first_element_i,
  input  logic                            last_element_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      out_byte_o
);
  import qdpr_pkg::*;

  cfg_t   cfg;
  logic   f_push, f_ready;
  qitem_t f_item;
  logic   b_pop, b_valid;
  qitem_t b_item;

  // configuration registers
  qdpr_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // intake and product
  qdpr_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .push_i          (push),
    .full_o          (full),
    .act_elem_i      (act_elem_i),
    .wgt_elem_i      (wgt_elem_i),
    .bias_value_i    (bias_value_i),
    .first_element_i (first_element_i),
    .last_element_i  (last_element_i),
    .q_push_o        (f_push),
    .q_ready_i       (f_ready),
    .q_item_o        (f_item)
  );

  // decoupling queue
  qdpr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .ready_o (f_ready),
    .item_i  (f_item),
    .pop_i   (b_pop),
    .valid_o (b_valid),
    .item_o  (b_item)
  );

  // accumulate and requantize
  qdpr_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_pop_o    (b_pop),
    .q_valid_i  (b_valid),
    .q_item_i   (b_item),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_byte_o (out_byte_o)
  );

endmodule

`default_nettype wire

### hw/rtl/qdpr_regs.sv
// Configuration register file of the requantizer.
// Depends on qdpr_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [qdpr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [qdpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output qdpr_pkg::cfg_t                 cfg_o
);
  import qdpr_pkg::*;

  cfg_t cfg_q, cfg_d;

  // writes always taken
  assign cfg_ready_o = 1'b1;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ACT_ZP:      cfg_d.act_zp      = cfg_data_i[7:0];
        CFG_WGT_ZP:      cfg_d.wgt_zp      = cfg_data_i[7:0];
        CFG_OUT_ZP:      cfg_d.out_zp      = cfg_data_i[8:0];
        CFG_SCALE_MULT:  cfg_d.scale_mult  = cfg_data_i[7:0];
        CFG_SCALE_SHIFT: cfg_d.scale_shift = cfg_data_i[4:0];
        CFG_ROUND_MODE:  cfg_d.round_mode  = cfg_data_i[1:0];
        CFG_SIGNED_OUT:  cfg_d.signed_out  = cfg_data_i[0];
        CFG_RELU_EN:     cfg_d.relu_en     = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // defaults: all zero but half-up rounding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{round_mode: RND_HALF_UP, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/qdpr_front.sv
// Front end: accepts input words, removes zero points, forms the product.
// Depends on qdpr_pkg for cfg_t and qitem_t.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  qdpr_pkg::cfg_t                cfg_i,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [7:0]                    act_elem_i,
  input  logic signed [7:0]             wgt_elem_i,
  input  logic signed [qdpr_pkg::BIAS_W-1:0] bias_value_i,
  input  logic                          first_element_i,
  input  logic                          last_element_i,
  output logic                          q_push_o,
  input  logic                          q_ready_i,
  output qdpr_pkg::qitem_t              q_item_o
);
  import qdpr_pkg::*;

  logic              f_valid_q, f_valid_d;
  qitem_t            f_item_q, f_item_d;
  logic              accept;
  logic signed [8:0] a_diff;
  logic signed [8:0] w_diff;
  logic signed [PROD_W-1:0] prod;

  // zero point removal and 9x9 product
  assign a_diff = $signed({1'b0, act_elem_i}) - $signed({1'b0, cfg_i.act_zp});
  assign w_diff = 9'(wgt_elem_i) - 9'($signed(cfg_i.wgt_zp));
  assign prod   = a_diff * w_diff;

  // stage is free when empty or draining into the queue
  assign full_o = f_valid_q && !q_ready_i;
  assign accept = push_i && !full_o;

  always_comb begin
    f_valid_d = f_valid_q;
    f_item_d  = f_item_q;
    if (accept) begin
      f_valid_d      = 1'b1;
      f_item_d.prod  = prod;
      f_item_d.bias  = bias_value_i;
      f_item_d.first = first_element_i;
      f_item_d.last  = last_element_i;
    end else if (q_ready_i) begin
      f_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_item_q <= f_item_d;
  end

  assign q_push_o = f_valid_q;
  assign q_item_o = f_item_q;

endmodule

`default_nettype wire

### hw/rtl/qdpr_fifo.sv
// Short word queue between front and back.
// Depends on qdpr_pkg for qitem_t.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_fifo #(
  parameter int DEPTH = qdpr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             ready_o,
  input  qdpr_pkg::qitem_t item_i,
  input  logic             pop_i,
  output logic             valid_o,
  output qdpr_pkg::qitem_t item_o
);
  import qdpr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qitem_t        mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  // full queue still takes a word when one leaves in the same cycle
  assign valid_o = (cnt_q != '0);
  assign ready_o = (cnt_q != CW'(DEPTH)) || pop_i;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/qdpr_back.sv
// Back end: accumulates products and requantizes finished sums.
// Depends on qdpr_pkg for cfg_t, qitem_t, rounding codes and masks.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_back #(
  parameter int ACC_WIDTH = qdpr_pkg::ACC_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qdpr_pkg::cfg_t   cfg_i,
  output logic             q_pop_o,
  input  logic             q_valid_i,
  input  qdpr_pkg::qitem_t q_item_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [7:0]       out_byte_o
);
  import qdpr_pkg::*;

  localparam int TW = ACC_WIDTH + 9;

  logic                        adv;
  logic                        take;
  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0] sum_q;
  logic signed [TW-1:0]        t_q, t_d;
  logic signed [TW-1:0]        r_q, r_d;
  logic [7:0]                  o_q, o_d;
  logic                        m_valid_q, p_valid_q, r_valid_q, o_valid_q;
  logic signed [TW-1:0]        sh;
  logic [TW-1:0]               bitpos, rmask;
  logic                        rbit, lbit, sticky, inc;
  logic [SAT_W-1:0]            v;
  logic [7:0]                  sat, floor_byte;

  // whole pipe moves unless the output word is stuck
  assign adv     = !o_valid_q || pop_i;
  assign q_pop_o = adv;
  assign take    = adv && q_valid_i;

  // accumulate, bias seeds a new dot product
  assign acc_d = (q_item_i.first ? ACC_WIDTH'($signed(q_item_i.bias)) : acc_q)
               + ACC_WIDTH'($signed(q_item_i.prod));

  // scale multiply
  assign t_d = sum_q * $signed({1'b0, cfg_i.scale_mult});

  // shift with rounding increment
  assign sh     = t_q >>> cfg_i.scale_shift;
  assign bitpos = TW'(1) << cfg_i.scale_shift;
  assign rmask  = bitpos >> 1;
  assign rbit   = |(t_q & rmask);
  assign lbit   = |(t_q & bitpos);
  assign sticky = (cfg_i.scale_shift != '0) && (|(t_q & (rmask - 1'b1)));

  always_comb begin
    case (cfg_i.round_mode)
      RND_HALF_UP:   inc = rbit;
      RND_HALF_EVEN: inc = rbit && (lbit || sticky);
      default:       inc = 1'b0;
    endcase
  end

  assign r_d = sh + TW'(inc);

  // offset, saturation and relu floor on the 40-bit value
  assign v          = SAT_W'(r_q) + SAT_W'($signed(cfg_i.out_zp));
  assign floor_byte = cfg_i.out_zp[7:0];

  always_comb begin
    if (cfg_i.signed_out) begin
      if ((v & MASK_B39) != '0) begin
        sat = ((v & MASK_B7_38) == MASK_B7_38) ? {1'b1, v[6:0]} : SAT_NEG_S;
      end else begin
        sat = ((v & MASK_B7_38) != '0) ? SAT_POS_S : {1'b0, v[6:0]};
      end
    end else begin
      if ((v & MASK_B8_39) != '0) begin
        sat = ((v & MASK_B39) != '0) ? SAT_NEG_U : SAT_POS_U;
      end else begin
        sat = v[7:0];
      end
    end
    o_d = sat;
    if (cfg_i.relu_en) begin
      if (cfg_i.signed_out) begin
        if ($signed(sat) < $signed(floor_byte)) begin
          o_d = floor_byte;
        end
      end else if (sat < floor_byte) begin
        o_d = floor_byte;
      end
    end
  end

  // control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv) begin
      if (take) begin
        acc_q <= acc_d;
      end
      m_valid_q <= take && q_item_i.last;
      p_valid_q <= m_valid_q;
      r_valid_q <= p_valid_q;
      o_valid_q <= r_valid_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= acc_d;
      t_q   <= t_d;
      r_q   <= r_d;
      o_q   <= o_d;
    end
  end

  assign empty_o    = !o_valid_q;
  assign out_byte_o = o_q;

endmodule

`default_nettype wire

### hw/rtl/qdpr_checker.sv
// Port-level checks of the requantizer top level, bound to it below.
// No package dependency; sees only the top level's handshake and result ports.
`timescale 1ns / 1ps
`default_nettype none

module qdpr_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       full_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] out_byte_i
);

  // nothing to deliver once a reset edge has been seen
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty_i)
    else $error("result shown after reset");

  // input backpressure only comes from a result that waits
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_i |-> !empty_i)
    else $error("input blocked with no result waiting");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(out_byte_i)))
    else $error("waiting result changed or vanished");

endmodule

bind quantized_dot_product_requantizer_core qdpr_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full_i     (full),
  .empty_i    (empty),
  .pop_i      (pop),
  .out_byte_i (out_byte_o)
);

`default_nettype wire
